// ===== rtl/sctp_pkg.sv =====
// Shared types and constants for the set-associative cache tag and policy core.
// Used by the core top level in rtl/ and by verif/tb.sv; depends on nothing.
`timescale 1ns / 1ps
package sctp_pkg;

  localparam int DEF_MAX_SETS     = 1024;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDRESS_BITS = 32;

  localparam int TAG_W   = 30;
  localparam int STAMP_W = 32;
  localparam int RANK_W  = 3;
  localparam int CYC_W   = 16;

  localparam logic [CYC_W-1:0]  MEM_WORD_CYCLES = 16'd100;
  localparam logic [3:0]        WORD_BYTES_LOG2 = 4'd2;
  localparam logic [RANK_W-1:0] RANK_MAX        = 3'd7;
  localparam logic [3:0]        OFF_MIN         = 4'd2;
  localparam logic [3:0]        OFF_MAX         = 4'd10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_BACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU    = 3'd5;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic             is_hit;
    logic [CYC_W-1:0] access_cycles;
    logic             wrote_back;
    logic             evicted;
    logic             bad_mode_error;
    logic [31:0]      load_count;
    logic [31:0]      store_count;
    logic [31:0]      load_hit_count;
    logic [31:0]      load_miss_count;
    logic [31:0]      store_hit_count;
    logic [31:0]      store_miss_count;
    logic [63:0]      cycle_total;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic               dirty;
    logic [RANK_W-1:0]  rank;
    logic [STAMP_W-1:0] stamp;
  } line_t;

endpackage

// ===== rtl/sctp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
module sctp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/set_associative_cache_tag_policy_core.sv =====
// Top level of the set-associative cache tag and policy core.
// Depends on sctp_pkg and sctp_ram (one row of all ways per set).
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------
//  input   | start, busy, in_data           | transfer when start && !busy
//  result  | out_valid, out_data            | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_wdata   | write when cfg_we
//
// An access steps through the set read, the shared tag/victim compare over
// each way in use in turn, and a step that writes the set back and registers
// the result. Busy drops with the strobe, so the next transfer can land on
// the edge that takes the result. After reset the set RAM is cleared one row
// a cycle with busy high. The receiver cannot stall.
`timescale 1ns / 1ps
module set_associative_cache_tag_policy_core #(
  parameter int MAX_SETS     = sctp_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS     = sctp_pkg::DEF_MAX_WAYS,
  parameter int ADDRESS_BITS = sctp_pkg::DEF_ADDRESS_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  sctp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output sctp_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sctp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sctp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SB    = $clog2(MAX_SETS + 1) - 1;
  localparam int DEPTH = 1 << SB;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW   = $clog2(MAX_WAYS + 1);
  localparam int LW    = $bits(sctp_pkg::line_t);
  localparam logic [31:0] AMASK = 32'hFFFF_FFFF >> (32 - ADDRESS_BITS);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_SCAN, ST_UPDATE} state_t;

  state_t st_r;

  // configuration
  logic [3:0] set_bits_r, ways_r, off_bits_r;
  logic       wr_alloc_r, wr_back_r, use_lru_r;

  // access context
  logic                        store_r;
  logic [AW-1:0]               set_r;
  logic [sctp_pkg::TAG_W-1:0]  tag_r;
  logic [AW-1:0]               clr_r;
  logic [WW-1:0]               way_r;
  logic                        hit_r, inv_r;
  logic [WW-1:0]               hit_way_r, inv_way_r, vic_way_r;
  logic [31:0]                 best_r;
  logic [31:0]                 seq_r, seq_nxt;

  // totals and flags
  logic [31:0] loads_r, stores_r, lhit_r, lmiss_r, shit_r, smiss_r;
  logic [63:0] cyc_tot_r;
  logic        o_hit_r, o_wrote_r, o_ev_r, o_err_r, out_valid_r;
  logic [sctp_pkg::CYC_W-1:0] o_cyc_r;

  // ram
  sctp_pkg::line_t [MAX_WAYS-1:0] rd_row, new_row;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [MAX_WAYS*LW-1:0] ram_wdata, ram_rdata;

  // effective geometry
  logic [4:0]       sbits;
  logic [3:0]       off_eff;
  logic [5:0]       ways_wide;
  logic [WCW-1:0]   ways_eff;
  logic [31:0]      addr;
  logic [31:0]      set_full;
  logic [31:0]      tag_full;
  logic [sctp_pkg::CYC_W-1:0] block_cost;

  always_comb begin
    sbits = (5'(set_bits_r) < 5'(SB)) ? 5'(set_bits_r) : 5'(SB);
    off_eff = off_bits_r;
    if (off_eff < sctp_pkg::OFF_MIN) off_eff = sctp_pkg::OFF_MIN;
    if (off_eff > sctp_pkg::OFF_MAX) off_eff = sctp_pkg::OFF_MAX;
    ways_wide = (ways_r == 4'd0) ? 6'd1 : 6'(ways_r);
    if (ways_wide > 6'(MAX_WAYS)) ways_wide = 6'(MAX_WAYS);
    ways_eff = WCW'(ways_wide);
    addr = in_data.address & AMASK;
    set_full = (addr >> off_eff) & ((32'd1 << sbits) - 32'd1);
    tag_full = addr >> (5'(off_eff) + sbits);
    block_cost = (sctp_pkg::CYC_W'(1) << (off_eff - sctp_pkg::WORD_BYTES_LOG2))
                 * sctp_pkg::MEM_WORD_CYCLES;
  end

  // shared compare unit, one way per scan cycle
  sctp_pkg::line_t scan_line;
  logic [31:0]     scan_key;
  logic            scan_last;

  always_comb begin
    scan_line = rd_row[way_r];
    scan_key  = use_lru_r ? 32'(scan_line.rank) : (seq_r - scan_line.stamp);
    scan_last = (WCW'(way_r) == ways_eff - WCW'(1));
  end

  // set update
  logic [WW-1:0]              w_sel;
  logic                       alloc, fresh, do_touch;
  logic [sctp_pkg::RANK_W-1:0] ref_rank;
  logic [sctp_pkg::CYC_W-1:0] cyc;
  logic                       wrote, ev, err;

  always_comb begin
    w_sel    = hit_r ? hit_way_r : (inv_r ? inv_way_r : vic_way_r);
    alloc    = !(store_r && !wr_alloc_r);
    new_row  = rd_row;
    seq_nxt  = seq_r;
    cyc      = '0;
    wrote    = 1'b0;
    ev       = 1'b0;
    err      = 1'b0;
    fresh    = 1'b0;
    do_touch = 1'b0;
    ref_rank = rd_row[w_sel].rank;
    if (hit_r) begin
      cyc = sctp_pkg::CYC_W'(1);
      do_touch = use_lru_r;
      if (store_r) begin
        if (wr_back_r) new_row[w_sel].dirty = 1'b1;
        else cyc = cyc + sctp_pkg::MEM_WORD_CYCLES;
      end
    end else if (!alloc) begin
      if (wr_back_r) err = 1'b1;
      else cyc = sctp_pkg::MEM_WORD_CYCLES;
    end else begin
      if (!inv_r) begin
        ev = 1'b1;
        if (wr_back_r && rd_row[w_sel].dirty) begin
          wrote = 1'b1;
          cyc = cyc + block_cost;
        end
      end
      new_row[w_sel].valid = 1'b1;
      new_row[w_sel].tag   = tag_r;
      new_row[w_sel].dirty = 1'b0;
      if (use_lru_r) begin
        do_touch = 1'b1;
        fresh = 1'b1;
      end else begin
        new_row[w_sel].stamp = seq_r;
        seq_nxt = seq_r + 32'd1;
      end
      if (store_r) begin
        if (wr_back_r) new_row[w_sel].dirty = 1'b1;
        else cyc = cyc + sctp_pkg::MEM_WORD_CYCLES;
      end
      cyc = cyc + block_cost + sctp_pkg::CYC_W'(1);
    end
    if (do_touch) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i < int'(ways_eff) && i != int'(w_sel) && rd_row[i].valid &&
            (fresh || rd_row[i].rank < ref_rank) &&
            rd_row[i].rank < sctp_pkg::RANK_MAX) begin
          new_row[i].rank = rd_row[i].rank + sctp_pkg::RANK_W'(1);
        end
      end
      new_row[w_sel].rank = '0;
    end
  end

  assign ram_we    = (st_r == ST_CLEAR) || (st_r == ST_UPDATE);
  assign ram_waddr = (st_r == ST_CLEAR) ? clr_r : set_r;
  assign ram_wdata = (st_r == ST_CLEAR) ? '0 : new_row;
  assign ram_re    = (st_r == ST_READ);
  assign rd_row    = ram_rdata;

  sctp_ram #(
    .WIDTH(MAX_WAYS * LW),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_set_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(set_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      set_bits_r  <= 4'd0;
      ways_r      <= 4'd1;
      off_bits_r  <= 4'd2;
      wr_alloc_r  <= 1'b1;
      wr_back_r   <= 1'b0;
      use_lru_r   <= 1'b1;
      seq_r       <= '0;
      loads_r     <= '0;
      stores_r    <= '0;
      lhit_r      <= '0;
      lmiss_r     <= '0;
      shit_r      <= '0;
      smiss_r     <= '0;
      cyc_tot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          sctp_pkg::CFG_SET_BITS: set_bits_r <= cfg_wdata;
          sctp_pkg::CFG_WAYS:     ways_r     <= cfg_wdata;
          sctp_pkg::CFG_OFF_BITS: off_bits_r <= cfg_wdata;
          sctp_pkg::CFG_WR_ALLOC: wr_alloc_r <= cfg_wdata[0];
          sctp_pkg::CFG_WR_BACK:  wr_back_r  <= cfg_wdata[0];
          sctp_pkg::CFG_USE_LRU:  use_lru_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DEPTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            store_r <= in_data.opcode;
            set_r   <= AW'(set_full);
            tag_r   <= tag_full[sctp_pkg::TAG_W-1:0];
            st_r    <= ST_READ;
          end
        end
        ST_READ: begin
          way_r <= '0;
          hit_r <= 1'b0;
          inv_r <= 1'b0;
          st_r  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!hit_r && scan_line.valid && scan_line.tag == tag_r) begin
            hit_r     <= 1'b1;
            hit_way_r <= way_r;
          end
          if (!inv_r && !scan_line.valid) begin
            inv_r     <= 1'b1;
            inv_way_r <= way_r;
          end
          if (way_r == '0 || scan_key > best_r) begin
            best_r    <= scan_key;
            vic_way_r <= way_r;
          end
          way_r <= way_r + WW'(1);
          if (scan_last) st_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          seq_r <= seq_nxt;
          if (store_r) begin
            stores_r <= stores_r + 32'd1;
            if (hit_r) shit_r <= shit_r + 32'd1;
            else smiss_r <= smiss_r + 32'd1;
          end else begin
            loads_r <= loads_r + 32'd1;
            if (hit_r) lhit_r <= lhit_r + 32'd1;
            else lmiss_r <= lmiss_r + 32'd1;
          end
          cyc_tot_r   <= cyc_tot_r + 64'(cyc);
          o_hit_r     <= hit_r;
          o_cyc_r     <= cyc;
          o_wrote_r   <= wrote;
          o_ev_r      <= ev;
          o_err_r     <= err;
          out_valid_r <= 1'b1;
          st_r        <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.is_hit           = o_hit_r;
    out_data.access_cycles    = o_cyc_r;
    out_data.wrote_back       = o_wrote_r;
    out_data.evicted          = o_ev_r;
    out_data.bad_mode_error   = o_err_r;
    out_data.load_count       = loads_r;
    out_data.store_count      = stores_r;
    out_data.load_hit_count   = lhit_r;
    out_data.load_miss_count  = lmiss_r;
    out_data.store_hit_count  = shit_r;
    out_data.store_miss_count = smiss_r;
    out_data.cycle_total      = cyc_tot_r;
  end

`ifndef SYNTHESIS
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == ST_UPDATE)) else $error("strobe without set update");
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not start an access");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_hit) |-> (!out_data.evicted && !out_data.wrote_back))
    else $error("hit reported an eviction");
  a_err_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_mode_error) |->
      (!out_data.is_hit && out_data.access_cycles == '0)) else $error("bad mode cost");
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.wrote_back) |-> out_data.evicted)
    else $error("writeback without eviction");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for set_associative_cache_tag_policy_core.
// Predicts each access from its own tag/rank/stamp store under the current geometry and mode.
// Depends on rtl/sctp_pkg.sv and the core RTL.
`timescale 1ns / 1ps
module tb;

  localparam int SETS = 1024;
  localparam int WAYS = 8;
  localparam int SETTLE = 16;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  sctp_pkg::in_item_t   in_data;
  logic                 out_valid;
  sctp_pkg::out_item_t  out_data;
  logic                 cfg_we;
  logic [sctp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sctp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  set_associative_cache_tag_policy_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // cache image kept by the predictor
  bit          ln_valid [SETS*WAYS];
  bit [29:0]   ln_tag   [SETS*WAYS];
  bit          ln_dirty [SETS*WAYS];
  bit [2:0]    ln_rank  [SETS*WAYS];
  bit [31:0]   ln_stamp [SETS*WAYS];
  bit [31:0]   fill_seq;
  bit [31:0]   n_loads, n_stores, n_load_hits, n_load_misses, n_store_hits, n_store_misses;
  bit [63:0]   n_cycles;
  bit [3:0]    r_set_bits, r_ways, r_off_bits;
  bit          r_alloc, r_wback, r_lru;

  sctp_pkg::out_item_t pending_results[$];
  int          errors;
  int          sender_idle_pct;
  bit [31:0]   addr_pool[16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void rank_touch(int base, int ways, int w, bit fresh);
    bit [2:0] r;
    r = ln_rank[base + w];
    for (int i = 0; i < ways; i++) begin
      if (i != w && ln_valid[base + i])
        if ((fresh || ln_rank[base + i] < r) && ln_rank[base + i] < sctp_pkg::RANK_MAX)
          ln_rank[base + i]++;
    end
    ln_rank[base + w] = '0;
  endfunction

  function automatic sctp_pkg::out_item_t predict_access(sctp_pkg::in_item_t it);
    sctp_pkg::out_item_t res;
    int         sb, ways, off, set, base, w, best_w;
    bit [29:0]  tag;
    bit [15:0]  block_cost, cyc;
    bit [31:0]  key, best;
    bit         hit, found, is_store;
    sb   = (r_set_bits > 4'd10) ? 10 : int'(r_set_bits);
    ways = (r_ways == 4'd0) ? 1 : (r_ways > 4'(WAYS)) ? WAYS : int'(r_ways);
    off  = (r_off_bits < 4'd2) ? 2 : (r_off_bits > 4'd10) ? 10 : int'(r_off_bits);
    is_store = it.opcode;
    set  = int'((it.address >> off) & ((32'd1 << sb) - 32'd1));
    tag  = 30'(it.address >> (off + sb));
    base = set * WAYS;
    block_cost = 16'((1 << (off - 2)) * 100);
    cyc = '0;
    hit = 1'b0;
    w = 0;
    res = '0;
    for (int i = 0; i < ways; i++) begin
      if (!hit && ln_valid[base + i] && ln_tag[base + i] == tag) begin
        hit = 1'b1;
        w = i;
      end
    end
    if (is_store) n_stores++; else n_loads++;
    if (hit) begin
      cyc = 16'd1;
      if (is_store) n_store_hits++; else n_load_hits++;
      if (r_lru) rank_touch(base, ways, w, 1'b0);
      if (is_store) begin
        if (r_wback) ln_dirty[base + w] = 1'b1;
        else cyc += sctp_pkg::MEM_WORD_CYCLES;
      end
    end else begin
      if (is_store) n_store_misses++; else n_load_misses++;
      if (is_store && !r_alloc) begin
        if (r_wback) res.bad_mode_error = 1'b1;
        else cyc = sctp_pkg::MEM_WORD_CYCLES;
      end else begin
        found = 1'b0;
        for (int i = 0; i < ways; i++) begin
          if (!found && !ln_valid[base + i]) begin
            w = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          best = '0;
          best_w = 0;
          for (int i = 0; i < ways; i++) begin
            key = r_lru ? 32'(ln_rank[base + i]) : fill_seq - ln_stamp[base + i];
            if (i == 0 || key > best) begin
              best = key;
              best_w = i;
            end
          end
          w = best_w;
          res.evicted = 1'b1;
          if (r_wback && ln_dirty[base + w]) begin
            res.wrote_back = 1'b1;
            cyc += block_cost;
          end
        end
        ln_valid[base + w] = 1'b1;
        ln_tag[base + w] = tag;
        ln_dirty[base + w] = 1'b0;
        if (r_lru) rank_touch(base, ways, w, 1'b1);
        else begin
          ln_stamp[base + w] = fill_seq;
          fill_seq++;
        end
        if (is_store) begin
          if (r_wback) ln_dirty[base + w] = 1'b1;
          else cyc += sctp_pkg::MEM_WORD_CYCLES;
        end
        cyc += block_cost + 16'd1;
      end
    end
    n_cycles += 64'(cyc);
    res.is_hit           = hit;
    res.access_cycles    = cyc;
    res.load_count       = n_loads;
    res.store_count      = n_stores;
    res.load_hit_count   = n_load_hits;
    res.load_miss_count  = n_load_misses;
    res.store_hit_count  = n_store_hits;
    res.store_miss_count = n_store_misses;
    res.cycle_total      = n_cycles;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sctp_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("is_hit", 64'(want.is_hit), 64'(out_data.is_hit));
        check_field("access_cycles", 64'(want.access_cycles),
                    64'(out_data.access_cycles));
        check_field("wrote_back", 64'(want.wrote_back), 64'(out_data.wrote_back));
        check_field("evicted", 64'(want.evicted), 64'(out_data.evicted));
        check_field("bad_mode_error", 64'(want.bad_mode_error),
                    64'(out_data.bad_mode_error));
        check_field("load_count", 64'(want.load_count), 64'(out_data.load_count));
        check_field("store_count", 64'(want.store_count), 64'(out_data.store_count));
        check_field("load_hit_count", 64'(want.load_hit_count),
                    64'(out_data.load_hit_count));
        check_field("load_miss_count", 64'(want.load_miss_count),
                    64'(out_data.load_miss_count));
        check_field("store_hit_count", 64'(want.store_hit_count),
                    64'(out_data.store_hit_count));
        check_field("store_miss_count", 64'(want.store_miss_count),
                    64'(out_data.store_miss_count));
        check_field("cycle_total", want.cycle_total, out_data.cycle_total);
      end
    end
  end

  // start stays high between back-to-back transfers; lower it only for a gap
  task automatic send_access(bit is_store, bit [31:0] addr);
    sctp_pkg::in_item_t it;
    int gap;
    it.opcode = is_store;
    it.address = addr;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_access(it));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [sctp_pkg::CFG_IDX_W-1:0] idx,
                           logic [sctp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sctp_pkg::CFG_SET_BITS: r_set_bits = val;
      sctp_pkg::CFG_WAYS:     r_ways = val;
      sctp_pkg::CFG_OFF_BITS: r_off_bits = val;
      sctp_pkg::CFG_WR_ALLOC: r_alloc = val[0];
      sctp_pkg::CFG_WR_BACK:  r_wback = val[0];
      sctp_pkg::CFG_USE_LRU:  r_lru = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(bit [3:0] sb, bit [3:0] ways, bit [3:0] off,
                              bit alloc, bit wback, bit lru);
    drain();
    write_reg(sctp_pkg::CFG_SET_BITS, sb);
    write_reg(sctp_pkg::CFG_WAYS, ways);
    write_reg(sctp_pkg::CFG_OFF_BITS, off);
    write_reg(sctp_pkg::CFG_WR_ALLOC, 4'(alloc));
    write_reg(sctp_pkg::CFG_WR_BACK, 4'(wback));
    write_reg(sctp_pkg::CFG_USE_LRU, 4'(lru));
  endtask

  task automatic test_direct_mapped;
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0003);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b0, 32'hffff_ffff);
    send_access(1'b1, 32'hffff_fffc);
    send_access(1'b1, 32'h0000_0010);
  endtask

  task automatic test_write_back_eviction;
    apply_config(4'd1, 4'd2, 4'd4, 1'b1, 1'b1, 1'b1);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0100);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0200);
    send_access(1'b1, 32'h0000_0300);
    send_access(1'b0, 32'h0000_0000);
  endtask

  task automatic test_no_allocate;
    apply_config(4'd0, 4'd1, 4'd2, 1'b0, 1'b1, 1'b1);
    send_access(1'b1, 32'h0000_4000);
    send_access(1'b0, 32'h0000_4000);
    send_access(1'b1, 32'h0000_4000);
    apply_config(4'd0, 4'd1, 4'd2, 1'b0, 1'b0, 1'b1);
    send_access(1'b1, 32'h0000_8000);
    send_access(1'b1, 32'h0000_4000);
  endtask

  task automatic test_geometry_clamp;
    apply_config(4'd15, 4'd0, 4'd0, 1'b1, 1'b0, 1'b0);
    send_access(1'b0, 32'h1234_5678);
    send_access(1'b0, 32'h1234_5678);
    apply_config(4'd15, 4'd15, 4'd15, 1'b1, 1'b1, 1'b0);
    send_access(1'b1, 32'h8000_0000);
    send_access(1'b0, 32'h8000_0000);
    send_access(1'b0, 32'h7fff_ffff);
  endtask

  task automatic run_phase(int count);
    bit [31:0] a;
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(7))
        0: a = $urandom();
        // flip high bits only: other tag, same set only where set bits lie below the shift
        1: a = addr_pool[$urandom_range(15)] ^ ($urandom() << $urandom_range(12, 24));
        default: a = addr_pool[$urandom_range(15)] ^ 32'($urandom_range(0, 3));
      endcase
      send_access(1'($urandom_range(1)), a);
    end
  endtask

  task automatic test_random_mix;
    apply_config(4'd0, 4'd8, 4'd2, 1'b1, 1'b1, 1'b1);
    run_phase(240);
    apply_config(4'd2, 4'd4, 4'd3, 1'b1, 1'b1, 1'b0);
    run_phase(240);
    // hold until the pipe is empty, then resume
    drain();
    run_phase(200);
    sender_idle_pct = 70;
    apply_config(4'd10, 4'd8, 4'd10, 1'b1, 1'b0, 1'b1);
    run_phase(240);
    apply_config(4'd1, 4'd3, 4'd2, 1'b0, 1'b0, 1'b0);
    run_phase(240);
    apply_config(4'd3, 4'd15, 4'd15, 1'b0, 1'b1, 1'b1);
    run_phase(200);
    sender_idle_pct = 0;
    apply_config(4'd2, 4'd0, 4'd0, 1'b1, 1'b1, 1'b0);
    run_phase(240);
    apply_config(4'd1, 4'd8, 4'd5, 1'b1, 1'b0, 1'b0);
    run_phase(325);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    errors = 0;
    sender_idle_pct = 37;
    r_set_bits = 4'd0;
    r_ways = 4'd1;
    r_off_bits = 4'd2;
    r_alloc = 1'b1;
    r_wback = 1'b0;
    r_lru = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // wait out the post-reset clearing pass
    while (busy !== 1'b0) @(posedge clk);
    test_direct_mapped();
    test_write_back_eviction();
    test_no_allocate();
    test_geometry_clamp();
    test_random_mix();
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
